>>> design/lpse_pkg.sv
// Package for the LED pulse-slot encoder: widths, register indexes, job and status types,
// and the slot-pattern helper functions. Depends on nothing; every other file imports it.
`default_nettype none

package lpse_pkg;

    localparam int PIX_W         = 24;
    localparam int BYTE_W        = 8;
    localparam int SLOTS_PER_BIT = 6;
    localparam int SLOT_CNT_W    = 3;
    localparam int NIB_W         = 4;
    localparam int WORD_W        = NIB_W * SLOTS_PER_BIT;  // 24 slots = 3 bytes
    localparam int GROUPS        = PIX_W / NIB_W;          // 6 groups of 4 colour bits
    localparam int GRP_W         = $clog2(GROUPS);
    localparam int PH_W          = 2;

    localparam logic [PH_W-1:0] PH_HI  = 2'd0;
    localparam logic [PH_W-1:0] PH_MID = 2'd1;
    localparam logic [PH_W-1:0] PH_LO  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd1;

    localparam logic [SLOT_CNT_W-1:0] ZERO_HIGH_RST = 3'd2;
    localparam logic [SLOT_CNT_W-1:0] ONE_HIGH_RST  = 3'd4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] grb;
        logic             first;
        logic             last;
    } t_job;

    typedef struct packed {
        logic [SLOT_CNT_W-1:0] zero_n;
        logic [SLOT_CNT_W-1:0] one_n;
    } t_slot_cfg;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    // Red 23-16, green 15-8, blue 7-0 becomes green, red, blue.
    function automatic logic [PIX_W-1:0] reorder_grb(input logic [PIX_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

    // Values above the slot count saturate to all slots high.
    function automatic logic [SLOT_CNT_W-1:0] clamp_slots(input logic [SLOT_CNT_W-1:0] n);
        return (n > SLOT_CNT_W'(SLOTS_PER_BIT)) ? SLOT_CNT_W'(SLOTS_PER_BIT) : n;
    endfunction

    // Top n slots high, the rest low; n is already clamped.
    function automatic logic [SLOTS_PER_BIT-1:0] therm(input logic [SLOT_CNT_W-1:0] n);
        logic [SLOTS_PER_BIT-1:0] ones;
        ones = '1;
        return ~(ones >> n);
    endfunction

    // Slot pattern of four colour bits, the most significant one first.
    function automatic logic [WORD_W-1:0] slot_word(input logic [NIB_W-1:0] nib,
                                                    input t_slot_cfg cfg);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int k = 0; k < NIB_W; k++) begin
            w[WORD_W-1-k*SLOTS_PER_BIT -: SLOTS_PER_BIT] =
                therm(nib[NIB_W-1-k] ? cfg.one_n : cfg.zero_n);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/lpse_ifs.sv
// Handshake interfaces of the encoder: pixel input, configuration write and line-byte output.
// Depends on lpse_pkg for the field widths.
`default_nettype none

interface lpse_pix_if;
    import lpse_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_color;
    logic             first_pixel;
    logic             last_pixel;
    modport source(output valid, pixel_color, first_pixel, last_pixel, input ready);
    modport sink(input valid, pixel_color, first_pixel, last_pixel, output ready);
endinterface

interface lpse_cfg_if;
    import lpse_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [SLOT_CNT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

interface lpse_line_if;
    import lpse_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              pixel_done;
    logic              frame_done;
    modport source(output valid, line_byte, pixel_done, frame_done, input ready);
    modport sink(input valid, line_byte, pixel_done, frame_done, output ready);
endinterface

`default_nettype wire

>>> design/lpse_front.sv
// Front end: accepts pixels while the job queue has room and turns them into GRB jobs.
// Depends on lpse_pkg and the pixel interface in lpse_ifs.
`default_nettype none

module lpse_front (
    lpse_pix_if.sink        i_pix,
    input  logic            i_q_full,
    output logic            o_push,
    output lpse_pkg::t_job  o_job
);
    import lpse_pkg::*;

    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full;

    always_comb begin
        o_job.grb   = reorder_grb(i_pix.pixel_color);
        o_job.first = i_pix.first_pixel;
        o_job.last  = i_pix.last_pixel;
    end

endmodule

`default_nettype wire

>>> design/lpse_queue.sv
// Short job queue between the front end and the byte sequencer, held in flip-flops.
// Depends on lpse_pkg for the job and status types.
`default_nettype none

module lpse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lpse_pkg::t_job   i_job,
    input  logic             i_pop,
    output lpse_pkg::t_job   o_job,
    output lpse_pkg::t_q_stat o_stat
);
    import lpse_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // Pointers wrap at the depth, which need not be a power of two.
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

>>> design/lpse_back.sv
// Back end: walks one job through its optional lead byte and 18 slot bytes into the
// output register. Depends on lpse_pkg and the line interface in lpse_ifs.
`default_nettype none

module lpse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpse_pkg::t_slot_cfg i_cfg,
    input  lpse_pkg::t_q_stat  i_q_stat,
    input  lpse_pkg::t_job     i_job,
    output logic               o_pop,
    lpse_line_if.source        o_line
);
    import lpse_pkg::*;

    logic              r_busy, n_busy;
    logic              r_lead, n_lead;
    logic              r_last, n_last;
    logic [PIX_W-1:0]  r_grb, n_grb;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic [GRP_W-1:0]  r_grp, n_grp;

    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_opd, n_opd;
    logic              r_ofd, n_ofd;

    logic              adv;
    logic              emit;
    logic              emit_final;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] slot_byte;

    assign adv        = !r_ovalid || o_line.ready;
    assign emit       = adv && r_busy;
    assign emit_final = emit && !r_lead && (r_phase == PH_LO)
                        && (r_grp == GRP_W'(GROUPS - 1));
    assign o_pop      = adv && i_q_stat.valid && (!r_busy || emit_final);

    assign word = slot_word(r_grb[PIX_W-1 -: NIB_W], i_cfg);

    always_comb begin
        case (r_phase)
            PH_HI:   slot_byte = word[WORD_W-1 -: BYTE_W];
            PH_MID:  slot_byte = word[WORD_W-1-BYTE_W -: BYTE_W];
            PH_LO:   slot_byte = word[BYTE_W-1:0];
            default: slot_byte = '0;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_lead   = r_lead;
        n_last   = r_last;
        n_grb    = r_grb;
        n_phase  = r_phase;
        n_grp    = r_grp;
        n_ovalid = r_ovalid && !o_line.ready;
        n_obyte  = r_obyte;
        n_opd    = r_opd;
        n_ofd    = r_ofd;

        if (emit) begin
            n_ovalid = 1'b1;
            if (r_lead) begin
                n_obyte = '0;
                n_opd   = 1'b0;
                n_ofd   = 1'b0;
                n_lead  = 1'b0;
            end else begin
                n_obyte = slot_byte;
                n_opd   = emit_final;
                n_ofd   = emit_final && r_last;
                if (r_phase == PH_LO) begin
                    n_phase = PH_HI;
                    n_grp   = r_grp + 1'b1;
                    n_grb   = r_grb << NIB_W;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
                if (emit_final) begin
                    n_busy = 1'b0;
                end
            end
        end

        if (o_pop) begin
            n_busy  = 1'b1;
            n_lead  = i_job.first;
            n_last  = i_job.last;
            n_grb   = i_job.grb;
            n_phase = PH_HI;
            n_grp   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead  <= n_lead;
        r_last  <= n_last;
        r_grb   <= n_grb;
        r_phase <= n_phase;
        r_grp   <= n_grp;
        r_obyte <= n_obyte;
        r_opd   <= n_opd;
        r_ofd   <= n_ofd;
    end

    assign o_line.valid      = r_ovalid;
    assign o_line.line_byte  = r_obyte;
    assign o_line.pixel_done = r_opd;
    assign o_line.frame_done = r_ofd;

endmodule

`default_nettype wire

>>> design/led_pulse_slot_encoder.sv
// Top level of the LED pulse-slot encoder: configuration registers, front end, job queue
// and byte sequencer. Depends on lpse_pkg, lpse_ifs, lpse_front, lpse_queue and lpse_back.
//
//   Channel  Direction  Payload                                   Handshake
//   i_pix    in         pixel_color[23:0], first_pixel, last_pixel  valid/ready
//   i_cfg    in         index[1:0], data[2:0]                      valid/ready
//   o_line   out        line_byte[7:0], pixel_done, frame_done     valid/ready
//
// A pixel yields 18 bytes, 19 when it starts a frame, at one byte per cycle from the output
// register while o_line is ready. From acceptance, a pixel passes through the job queue
// and the back end's job registers before its first byte shows on o_line.
// Reset sets the slot counts to 2 and 4 and empties the queue and the output register.
// A stalled o_line holds its byte; the two-entry queue takes up to two more pixels
// meanwhile, after which i_pix drops ready until the back end pops a job.
`default_nettype none

module led_pulse_slot_encoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpse_pix_if.sink     i_pix,
    lpse_cfg_if.sink     i_cfg,
    lpse_line_if.source  o_line
);
    import lpse_pkg::*;

    t_slot_cfg r_cfg;
    t_job      push_job;
    t_job      head_job;
    t_q_stat   q_stat;
    logic      push;
    logic      pop;

    // Configuration registers. Counts above the slot count are stored saturated, which
    // gives the same patterns, and an index beyond the register list is ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_n <= ZERO_HIGH_RST;
            r_cfg.one_n  <= ONE_HIGH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ZERO_HIGH: r_cfg.zero_n <= clamp_slots(i_cfg.data);
                REG_ONE_HIGH:  r_cfg.one_n  <= clamp_slots(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    // The front end takes a pixel whenever the queue has a free entry.
    lpse_front u_front (
        .i_pix    (i_pix),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (push_job)
    );

    lpse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // The back end pops the next job in the same cycle as it emits the final byte of the
    // current one, so consecutive pixels stream without a gap.
    lpse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_line   (o_line)
    );

`ifndef SYNTHESIS
    // The queue never holds more jobs than it has entries.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("job queue count above depth");

    // A lone push grows the queue by exactly one entry.
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("job queue count did not follow a push");

    // The back end only pops a job that is there.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.valid)
        else $error("pop from an empty job queue");

    // The end of a frame is always the end of a pixel.
    a_frame_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_line.valid && o_line.frame_done) |-> o_line.pixel_done)
        else $error("frame end marked on a byte that does not end a pixel");
`endif

endmodule

`default_nettype wire
